// ===== sv/assert_macros.svh =====
// assertion macros used by the rtl of the refraction block
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, switched off while reset is high
`define ASSERT_CLK_RST(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// clocked check that also holds through reset
`define ASSERT_CLK(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

// ===== sv/refr_pkg.sv =====
// types and constants for the refraction direction unit
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package refr_pkg;

   localparam int COMP_WIDTH    = 16;
   localparam int FRAC_BITS_DEF = 14;
   localparam int INDEX_WIDTH   = 15;
   // fraction bits of the internal fixed point format
   localparam int IFRAC         = 20;

   typedef struct packed {
      logic [INDEX_WIDTH-1:0]       index_incident;
      logic [INDEX_WIDTH-1:0]       index_transmitted;
      logic signed [COMP_WIDTH-1:0] inc_x;
      logic signed [COMP_WIDTH-1:0] inc_y;
      logic signed [COMP_WIDTH-1:0] inc_z;
      logic signed [COMP_WIDTH-1:0] norm_x;
      logic signed [COMP_WIDTH-1:0] norm_y;
      logic signed [COMP_WIDTH-1:0] norm_z;
   } req_type;

   typedef struct packed {
      logic signed [COMP_WIDTH-1:0] dir_x;
      logic signed [COMP_WIDTH-1:0] dir_y;
      logic signed [COMP_WIDTH-1:0] dir_z;
      logic                         refracted;
   } rsp_type;

endpackage

`default_nettype wire

// ===== sv/refraction_direction.sv =====
// refraction direction unit: pipelined snell's law on fixed point vectors
// depends on refr_pkg and assert_macros.svh
// pipeline: 28 register stages
// throughput: one request per cycle while rsp_ready does not stall the pipe;
// the eta divider (5 bits per stage) and the square root (2 digits per stage)
// are unrolled over stages, so nothing loops
// reset clears only the stage valid bits, the pipe comes up empty
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module refraction_direction #(
   parameter int FRAC_BITS = refr_pkg::FRAC_BITS_DEF
) (
   input  wire              clock,
   input  wire              reset,
   input  wire              req_valid,
   output logic             req_ready,
   input  wire refr_pkg::req_type req_data,
   output logic             rsp_valid,
   input  wire              rsp_ready,
   output refr_pkg::rsp_type rsp_data
);

   localparam int CW     = refr_pkg::COMP_WIDTH;
   localparam int IFRAC  = refr_pkg::IFRAC;
   localparam int IXW    = refr_pkg::INDEX_WIDTH;
   localparam int EXT_W  = CW + IFRAC;
   localparam int SH_UP  = (FRAC_BITS < IFRAC) ? IFRAC - FRAC_BITS : 0;
   localparam int SH_DN  = (FRAC_BITS >= IFRAC) ? FRAC_BITS - IFRAC : 0;
   localparam int OUT_SH = 2 * IFRAC - FRAC_BITS;

   // quotient bits of eta, the top part of the dividend sits in the remainder
   localparam int DIVB    = 25;
   localparam int DIV_PER = 5;
   localparam int DIV_ST  = DIVB / DIV_PER;
   localparam int SQ_DIG  = 30;
   localparam int SQ_PER  = 2;
   localparam int SQ_ST   = SQ_DIG / SQ_PER;

   localparam int ST_DIV0 = 1;
   localparam int ST_PROD = 1;
   localparam int ST_DOT  = 2;
   localparam int ST_C1   = 3;
   localparam int ST_ONEM = 4;
   localparam int ST_ETA  = ST_DIV0 + DIV_ST;
   localparam int ST_ETA2 = ST_ETA + 1;
   localparam int ST_PR   = ST_ETA2 + 1;
   localparam int ST_CS2  = ST_PR + 1;
   localparam int ST_SQ0  = ST_CS2 + 1;
   localparam int ST_K    = ST_SQ0 + SQ_ST;
   localparam int ST_AB   = ST_K + 1;
   localparam int ST_OUT  = ST_AB + 1;
   localparam int NST     = ST_OUT + 1;

   localparam logic signed [EXT_W-1:0] CMAX      = EXT_W'(64'sd8 <<< IFRAC);
   localparam logic signed [51:0]      C1_MAX    = 52'sd16 <<< IFRAC;
   localparam logic signed [51:0]      ONE_Q52   = 52'sd1 <<< IFRAC;
   localparam logic signed [40:0]      ONE_Q41   = 41'sd1 <<< IFRAC;
   localparam logic [DIVB-1:0]         ETA_MAX   = DIVB'(64'd16 << IFRAC);
   localparam logic signed [57:0]      OUT_HI    = (58'sd1 <<< (CW - 1)) - 58'sd1;
   localparam logic signed [57:0]      OUT_LO    = -OUT_HI - 58'sd1;

   typedef struct packed {
      logic [IXW-1:0]         n2;
      logic                   ovf;
      logic [IXW-1:0]         drem;
      logic [DIVB-1:0]        dsh;
      logic [DIVB-1:0]        quo;
      logic [2:0][24:0]       iv;
      logic [2:0][24:0]       nv;
      logic [2:0][49:0]       prod;
      logic [51:0]            dot;
      logic [25:0]            c1;
      logic [29:0]            onem;
      logic [24:0]            eta;
      logic [28:0]            eta2;
      logic [31:0]            etac1;
      logic [59:0]            pr;
      logic                   refr;
      logic [2*SQ_DIG-1:0]    sqv;
      logic [31:0]            srem;
      logic [SQ_DIG-1:0]      sroot;
      logic [31:0]            k;
      logic [2:0][50:0]       pa;
      logic [2:0][56:0]       pb;
      logic [2:0][CW-1:0]     dir;
   } stage_type;

   stage_type        st_ff [NST];
   stage_type        st_in [NST];
   logic [NST-1:0]   v_ff;
   logic [NST:0]     en;
   logic             req_fire;
   logic             rsp_fire;

   // component to internal format, saturated at +-8.0
   function automatic logic [24:0] comp_in(input logic [CW-1:0] raw);
      logic signed [EXT_W-1:0] xe;
      xe = $signed(raw);
      xe = (xe <<< SH_UP) >>> SH_DN;
      if (xe > CMAX) begin
         xe = CMAX;
      end else if (xe < -CMAX) begin
         xe = -CMAX;
      end
      return xe[24:0];
   endfunction

   // a stage moves when it is empty or the one after it moves
   always_comb begin
      en[NST] = rsp_ready;
      for (int s = NST - 1; s >= 0; s--) begin
         en[s] = !v_ff[s] || en[s+1];
      end
   end

   assign req_ready = en[0];
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = v_ff[NST-1];
   assign rsp_fire  = rsp_valid && rsp_ready;

   always_comb begin
      stage_type nx;
      nx       = '0;
      nx.n2    = req_data.index_transmitted;
      nx.drem  = IXW'(req_data.index_incident[IXW-1:5]);
      nx.dsh   = {req_data.index_incident[4:0], 20'b0};
      // quotient would need more than DIVB bits, also covers a zero divisor
      nx.ovf   = IXW'(req_data.index_incident[IXW-1:5]) >= req_data.index_transmitted;
      nx.iv[0] = comp_in(req_data.inc_x);
      nx.iv[1] = comp_in(req_data.inc_y);
      nx.iv[2] = comp_in(req_data.inc_z);
      nx.nv[0] = comp_in(req_data.norm_x);
      nx.nv[1] = comp_in(req_data.norm_y);
      nx.nv[2] = comp_in(req_data.norm_z);
      st_in[0] = nx;
   end

   for (genvar s = 1; s < NST; s++) begin : g_stage
      always_comb begin
         stage_type           nx;
         logic [IXW:0]        dt;
         logic [33:0]         sqt;
         logic [33:0]         sqtr;
         logic signed [49:0]  p50;
         logic signed [51:0]  w52;
         logic [49:0]         ee;
         logic signed [59:0]  p60;
         logic signed [40:0]  cs;
         logic signed [50:0]  a51;
         logic signed [56:0]  b57;
         logic signed [57:0]  sum;
         dt   = '0;
         sqt  = '0;
         sqtr = '0;
         p50  = '0;
         w52  = '0;
         ee   = '0;
         p60  = '0;
         cs   = '0;
         a51  = '0;
         b57  = '0;
         sum  = '0;
         nx   = st_ff[s-1];

         if (s >= ST_DIV0 && s < ST_DIV0 + DIV_ST) begin
            for (int j = 0; j < DIV_PER; j++) begin
               dt     = {nx.drem, nx.dsh[DIVB-1]};
               nx.dsh = nx.dsh << 1;
               if (dt >= {1'b0, nx.n2}) begin
                  nx.drem = IXW'(dt - {1'b0, nx.n2});
                  nx.quo  = {nx.quo[DIVB-2:0], 1'b1};
               end else begin
                  nx.drem = dt[IXW-1:0];
                  nx.quo  = {nx.quo[DIVB-2:0], 1'b0};
               end
            end
         end

         if (s == ST_PROD) begin
            for (int i = 0; i < 3; i++) begin
               p50        = $signed(nx.iv[i]) * $signed(nx.nv[i]);
               nx.prod[i] = p50;
            end
         end

         if (s == ST_DOT) begin
            w52    = $signed(nx.prod[0]) + $signed(nx.prod[1]) + $signed(nx.prod[2]);
            nx.dot = w52;
         end

         if (s == ST_C1) begin
            w52 = -($signed(nx.dot) >>> IFRAC);
            if (w52 > C1_MAX) begin
               w52 = C1_MAX;
            end else if (w52 < -C1_MAX) begin
               w52 = -C1_MAX;
            end
            nx.c1 = w52[25:0];
         end

         if (s == ST_ONEM) begin
            w52     = $signed(nx.c1) * $signed(nx.c1);
            w52     = ONE_Q52 - (w52 >>> IFRAC);
            nx.onem = w52[29:0];
         end

         if (s == ST_ETA) begin
            nx.eta = (nx.ovf || nx.quo > ETA_MAX) ? ETA_MAX : nx.quo;
         end

         if (s == ST_ETA2) begin
            ee       = nx.eta * nx.eta;
            nx.eta2  = 29'(ee >> IFRAC);
            w52      = $signed({1'b0, nx.eta}) * $signed(nx.c1);
            w52      = w52 >>> IFRAC;
            nx.etac1 = w52[31:0];
         end

         if (s == ST_PR) begin
            p60   = $signed({1'b0, nx.eta2}) * $signed(nx.onem);
            nx.pr = p60;
         end

         if (s == ST_CS2) begin
            p60      = $signed(nx.pr) >>> IFRAC;
            cs       = ONE_Q41 - p60[40:0];
            nx.refr  = !cs[40];
            // square root runs on cs2 scaled up by 2^IFRAC
            nx.sqv   = nx.refr ? {cs[39:0], 20'b0} : '0;
            nx.srem  = '0;
            nx.sroot = '0;
         end

         if (s >= ST_SQ0 && s < ST_SQ0 + SQ_ST) begin
            for (int j = 0; j < SQ_PER; j++) begin
               sqt    = {nx.srem, nx.sqv[2*SQ_DIG-1 -: 2]};
               nx.sqv = nx.sqv << 2;
               sqtr   = {2'b0, nx.sroot, 2'b01};
               if (sqt >= sqtr) begin
                  nx.srem  = 32'(sqt - sqtr);
                  nx.sroot = {nx.sroot[SQ_DIG-2:0], 1'b1};
               end else begin
                  nx.srem  = sqt[31:0];
                  nx.sroot = {nx.sroot[SQ_DIG-2:0], 1'b0};
               end
            end
         end

         if (s == ST_K) begin
            nx.k = 32'($signed(nx.etac1) - $signed({2'b0, nx.sroot}));
         end

         if (s == ST_AB) begin
            for (int i = 0; i < 3; i++) begin
               a51      = $signed({1'b0, nx.eta}) * $signed(nx.iv[i]);
               b57      = $signed(nx.k) * $signed(nx.nv[i]);
               nx.pa[i] = a51;
               nx.pb[i] = b57;
            end
         end

         if (s == ST_OUT) begin
            for (int i = 0; i < 3; i++) begin
               sum = $signed(nx.pa[i]) + $signed(nx.pb[i]);
               sum = sum >>> OUT_SH;
               if (sum > OUT_HI) begin
                  sum = OUT_HI;
               end else if (sum < OUT_LO) begin
                  sum = OUT_LO;
               end
               // total internal reflection gives a zero direction
               nx.dir[i] = nx.refr ? sum[CW-1:0] : '0;
            end
         end

         st_in[s] = nx;
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < NST; s++) begin
         if (en[s]) begin
            st_ff[s] <= st_in[s];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) begin
            v_ff[0] <= req_valid;
         end
         for (int s = 1; s < NST; s++) begin
            if (en[s]) begin
               v_ff[s] <= v_ff[s-1];
            end
         end
      end
   end

   assign rsp_data.dir_x     = $signed(st_ff[NST-1].dir[0]);
   assign rsp_data.dir_y     = $signed(st_ff[NST-1].dir[1]);
   assign rsp_data.dir_z     = $signed(st_ff[NST-1].dir[2]);
   assign rsp_data.refracted = st_ff[NST-1].refr;

   `ASSERT_CLK(a_reset_empties, clock, reset |=> (v_ff == '0))
   `ASSERT_CLK_RST(a_item_count, clock, reset, !$past(reset) |-> ($countones(v_ff) == $past($countones(v_ff)) + $past(req_fire) - $past(rsp_fire)))
   `ASSERT_CLK_RST(a_tir_zero, clock, reset, (rsp_valid && !rsp_data.refracted) |-> (rsp_data.dir_x == '0 && rsp_data.dir_y == '0 && rsp_data.dir_z == '0))
   `ASSERT_CLK_RST(a_head_free, clock, reset, !v_ff[0] |-> req_ready)

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// self-checking testbench for the refraction direction unit
// depends on refr_pkg and the refraction_direction rtl
`timescale 1ns / 1ps

module tb_top;

   localparam int COMP_WIDTH = refr_pkg::COMP_WIDTH;
   localparam int IFRAC = refr_pkg::IFRAC;
   localparam int FRAC = refr_pkg::FRAC_BITS_DEF;
   localparam longint ONE_Q = 64'sd1 <<< IFRAC;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   refr_pkg::req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   refr_pkg::rsp_type rsp_data;

   refr_pkg::req_type ray_queue[$];
   refr_pkg::rsp_type dir_expected[$];
   int      error_count = 0;
   int      sent_count = 0;
   int      got_count = 0;
   int      tir_count = 0;
   bit      quiet_phase = 1'b0;
   bit      hold_request = 1'b0;
   bit      req_ready_seen = 1'b0;

   refraction_direction i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic longint floor_shift(longint x, int s);
      return x >>> s;
   endfunction

   function automatic longint clamp_sym(longint x, longint lim);
      if (x > lim) return lim;
      if (x < -lim) return -lim;
      return x;
   endfunction

   function automatic longint widen_comp(logic signed [COMP_WIDTH-1:0] c);
      longint x;
      x = longint'(c) <<< (IFRAC - FRAC);
      return clamp_sym(x, 64'sd8 <<< IFRAC);
   endfunction

   function automatic longint int_sqrt(longint v);
      longint r;
      longint b;
      r = 0;
      b = 64'sd1 <<< 62;
      while (b > v) b = b >>> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >>> 1) + b;
         end else begin
            r = r >>> 1;
         end
         b = b >>> 2;
      end
      return r;
   endfunction

   function automatic logic signed [COMP_WIDTH-1:0] narrow_comp(longint q40);
      longint x;
      x = floor_shift(q40, 2 * IFRAC - FRAC);
      if (x > 32767) x = 32767;
      if (x < -32768) x = -32768;
      return x[COMP_WIDTH-1:0];
   endfunction

   function automatic refr_pkg::rsp_type refract_ray(refr_pkg::req_type r);
      refr_pkg::rsp_type o;
      longint iv[3];
      longint nv[3];
      longint eta, dot, c1, c1sq, eta2, cs2, k, q;
      iv[0] = widen_comp(r.inc_x);
      iv[1] = widen_comp(r.inc_y);
      iv[2] = widen_comp(r.inc_z);
      nv[0] = widen_comp(r.norm_x);
      nv[1] = widen_comp(r.norm_y);
      nv[2] = widen_comp(r.norm_z);
      if (r.index_transmitted == 0) begin
         eta = 64'sd16 <<< IFRAC;
      end else begin
         q = (longint'(r.index_incident) <<< IFRAC) / longint'(r.index_transmitted);
         eta = (q > (64'sd16 <<< IFRAC)) ? (64'sd16 <<< IFRAC) : q;
      end
      dot = iv[0] * nv[0] + iv[1] * nv[1] + iv[2] * nv[2];
      c1 = clamp_sym(-floor_shift(dot, IFRAC), 64'sd16 <<< IFRAC);
      c1sq = floor_shift(c1 * c1, IFRAC);
      eta2 = floor_shift(eta * eta, IFRAC);
      cs2 = ONE_Q - floor_shift(eta2 * (ONE_Q - c1sq), IFRAC);
      o = '0;
      if (cs2 < 0) return o;
      k = floor_shift(eta * c1, IFRAC) - int_sqrt(cs2 <<< IFRAC);
      o.dir_x = narrow_comp(eta * iv[0] + k * nv[0]);
      o.dir_y = narrow_comp(eta * iv[1] + k * nv[1]);
      o.dir_z = narrow_comp(eta * iv[2] + k * nv[2]);
      o.refracted = 1'b1;
      return o;
   endfunction

   // random vector component between -1.0 and +1.0
   function automatic logic [15:0] unitish();
      int v;
      v = $urandom_range(0, 16384);
      return $urandom_range(0, 1) ? 16'(v) : 16'(-v);
   endfunction

   function automatic refr_pkg::req_type random_ray();
      refr_pkg::req_type r;
      int mode;
      mode = $urandom_range(0, 9);
      r.index_incident = 15'($urandom_range(4096, 16384));
      r.index_transmitted = 15'($urandom_range(4096, 16384));
      if (mode == 0) begin
         r.index_incident = 15'($urandom);
         r.index_transmitted = 15'($urandom);
      end
      if (mode <= 2) begin
         {r.inc_x, r.inc_y, r.inc_z} = {16'($urandom), 16'($urandom), 16'($urandom)};
         {r.norm_x, r.norm_y, r.norm_z} = {16'($urandom), 16'($urandom), 16'($urandom)};
      end else begin
         r.inc_x = unitish(); r.inc_y = unitish(); r.inc_z = unitish();
         r.norm_x = unitish(); r.norm_y = unitish(); r.norm_z = unitish();
      end
      return r;
   endfunction

   function automatic refr_pkg::req_type make_ray(int n1, int n2, int ix, int iy, int iz,
                                                  int nx, int ny, int nz);
      refr_pkg::req_type r;
      r.index_incident = 15'(n1);
      r.index_transmitted = 15'(n2);
      r.inc_x = 16'(ix); r.inc_y = 16'(iy); r.inc_z = 16'(iz);
      r.norm_x = 16'(nx); r.norm_y = 16'(ny); r.norm_z = 16'(nz);
      return r;
   endfunction

   // sender: offers at falling edges, burst gaps
   int send_gap = 0;
   always @(negedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready_seen) begin
            sent_count++;
         end
         if (!req_valid || req_ready_seen) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (ray_queue.size() > 0) begin
               req_data <= ray_queue[0];
               dir_expected.push_back(refract_ray(ray_queue[0]));
               void'(ray_queue.pop_front());
               req_valid <= 1'b1;
               if (!quiet_phase && $urandom_range(0, 15) == 0)
                  send_gap = $urandom_range(1, 15);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // handshakes sampled at the rising edge
   always @(posedge clock) req_ready_seen <= req_valid && req_ready;

   // receiver with stall bursts
   int stall_left = 0;
   always @(negedge clock) begin
      if (!reset) begin
         if (hold_request) begin
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (!quiet_phase && $urandom_range(0, 12) == 0) begin
            stall_left = $urandom_range(1, 15);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // monitor: compare each result transfer with the oldest prediction
   always @(posedge clock) begin
      refr_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got_count++;
         if (dir_expected.size() == 0) begin
            $display("%0t: unexpected result %h", $time, rsp_data);
            error_count++;
         end else begin
            want = dir_expected.pop_front();
            if (!want.refracted) tir_count++;
            if (rsp_data.dir_x !== want.dir_x || rsp_data.dir_y !== want.dir_y ||
                rsp_data.dir_z !== want.dir_z || rsp_data.refracted !== want.refracted) begin
               $display("%0t: mismatch expected %0d %0d %0d r%0b actual %0d %0d %0d r%0b",
                        $time, want.dir_x, want.dir_y, want.dir_z, want.refracted,
                        rsp_data.dir_x, rsp_data.dir_y, rsp_data.dir_z,
                        rsp_data.refracted);
               error_count++;
            end
         end
      end
   end

   initial begin
      int hold_cycles;
      repeat (10) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // directed: normal incidence, glancing, tir, index extremes, big vectors
      ray_queue.push_back(make_ray(4096, 4096, 0, 0, -16384, 0, 0, 16384));
      ray_queue.push_back(make_ray(4096, 6144, 11585, 0, -11585, 0, 0, 16384));
      ray_queue.push_back(make_ray(6144, 4096, 11585, 0, -11585, 0, 0, 16384));
      ray_queue.push_back(make_ray(16384, 4096, 16384, 0, -100, 0, 0, 16384));
      ray_queue.push_back(make_ray(4096, 16384, 16384, 0, 0, 0, 0, 16384));
      ray_queue.push_back(make_ray(4096, 0, 0, 16384, 0, 0, 16384, 0));
      ray_queue.push_back(make_ray(32767, 1, 100, 200, 300, 0, 0, 16384));
      ray_queue.push_back(make_ray(0, 4096, 1000, -2000, 3000, 16384, 0, 0));
      ray_queue.push_back(make_ray(32767, 32767, -32768, -32768, -32768,
                                   -32768, -32768, -32768));
      ray_queue.push_back(make_ray(4096, 4096, 32767, 32767, 32767,
                                   32767, 32767, 32767));
      ray_queue.push_back(make_ray(4096, 4096, 32767, -32768, 32767,
                                   -32768, 32767, -32768));
      ray_queue.push_back(make_ray(4096, 4096, 16384, 0, 0, 0, 16384, 0));
      ray_queue.push_back(make_ray(8192, 4096, 11585, 0, -11585, 0, 0, 16384));
      ray_queue.push_back(make_ray(5793, 4096, 11585, 0, -11585, 0, 0, 16384));
      ray_queue.push_back(make_ray(4096, 4096, 0, 0, 0, 0, 0, 0));
      ray_queue.push_back(make_ray(32767, 32767, 21845, 0, 0, 0, 0, 0));

      // long receiver hold while the sender keeps offering
      for (int i = 0; i < 100; i++) ray_queue.push_back(random_ray());
      hold_request = 1'b1;
      hold_cycles = 0;
      while (hold_cycles < 150) begin
         @(posedge clock);
         hold_cycles++;
      end
      hold_request = 1'b0;

      for (int i = 0; i < 1500; i++) ray_queue.push_back(random_ray());
      wait (ray_queue.size() == 0);
      quiet_phase = 1'b1;
      for (int i = 0; i < 150; i++) ray_queue.push_back(random_ray());
      wait (ray_queue.size() == 0 && !req_valid);
      wait (dir_expected.size() == 0);
      repeat (60) @(posedge clock);
      $display("covered %0d rays, %0d results, %0d with total internal reflection",
               sent_count, got_count, tir_count);
      $display("including a long output stall and out-of-range indices and vectors");
      if (error_count == 0 && dir_expected.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   initial begin
      #4ms;
      $display("Some tests failed");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+sv
sv/refr_pkg.sv
sv/refraction_direction.sv
tb/tb_top.sv
